// ===== sv/deformable_im2col_sampler_macros.svh =====
// Assertion macros for the deformable im2col sampler checker.
// Included by the checker file; has no other dependency.
`ifndef DEFORMABLE_IM2COL_SAMPLER_MACROS_SVH
`define DEFORMABLE_IM2COL_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define DIS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define DIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dis_pkg.sv =====
// Shared constants for the deformable im2col sampler.
// No dependencies; used by the top level and the plane store.
package dis_pkg;

   localparam int DEF_MAX_HEIGHT = 64;
   localparam int DEF_MAX_WIDTH  = 64;

   localparam int PIX_W = 16;

   // item kinds on req_tuser
   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   // register indexes
   localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd0;
   localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
   localparam logic [2:0] REG_STRIDE_ROWS   = 3'd2;
   localparam logic [2:0] REG_STRIDE_COLS   = 3'd3;
   localparam logic [2:0] REG_PAD_ROWS      = 3'd4;
   localparam logic [2:0] REG_PAD_COLS      = 3'd5;
   localparam logic [2:0] REG_DILATION_ROWS = 3'd6;
   localparam logic [2:0] REG_DILATION_COLS = 3'd7;

endpackage

// ===== sv/dis_plane_mem.sv =====
// One copy of the image plane: one write port and two registered read ports.
// Depends on dis_pkg for the pixel width.
module dis_plane_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [dis_pkg::PIX_W-1:0]   wr_data,
   input  logic [AW-1:0]               rd_addr_a,
   input  logic [AW-1:0]               rd_addr_b,
   output logic [dis_pkg::PIX_W-1:0]   rd_data_a,
   output logic [dis_pkg::PIX_W-1:0]   rd_data_b
);

   logic [dis_pkg::PIX_W-1:0] mem_ff [DEPTH];
   logic [dis_pkg::PIX_W-1:0] rd_a_ff;
   logic [dis_pkg::PIX_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while the pipeline stalls
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== sv/deformable_im2col_sampler.sv =====
// Channel   | dir | payload
// req_      | in  | tuser: mode; tdata: load fields and sample request fields
// rsp_      | out | tuser: inside_res; tdata: sample_value
// csr_      | in  | csr_index: register index; csr_data: write value
//
// One item enters per cycle while req_tready is high.
// Stages: capture, position, floor/fraction, address/weights, plane read,
// products, then sum into the output register backed by a one-entry skid.
// Loads write the plane at the read stage, so reads and writes stay in order.
// Reset clears valid bits and sets the configuration registers to their defaults;
// the plane is undefined until loaded. A stall holds every stage; req_tready drops only when the skid is full.
module deformable_im2col_sampler #(
   parameter int MAX_HEIGHT = dis_pkg::DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH  = dis_pkg::DEF_MAX_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] mode
   // [11:0] pixel_index, [27:12] pixel_value, [31:28] kernel_row,
   // [35:32] kernel_col, [41:36] out_row, [47:42] out_col,
   // [63:48] offset_row, [79:64] offset_col
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,   // [0] inside_res
   output logic [15:0] rsp_tdata,   // [15:0] sample_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);

   localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [23:0] DEPTH_W = 24'(DEPTH);
   localparam logic [31:0] DEPTH_L = 32'(DEPTH);

   // configuration
   logic [6:0] height_ff, width_ff;
   logic [3:0] stride_r_ff, stride_c_ff, pad_r_ff, pad_c_ff, dil_r_ff, dil_c_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= 7'd64;
         width_ff    <= 7'd64;
         stride_r_ff <= 4'd1;
         stride_c_ff <= 4'd1;
         pad_r_ff    <= 4'd0;
         pad_c_ff    <= 4'd0;
         dil_r_ff    <= 4'd1;
         dil_c_ff    <= 4'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            dis_pkg::REG_IMAGE_HEIGHT:  height_ff   <= csr_data;
            dis_pkg::REG_IMAGE_WIDTH:   width_ff    <= csr_data;
            dis_pkg::REG_STRIDE_ROWS:   stride_r_ff <= csr_data[3:0];
            dis_pkg::REG_STRIDE_COLS:   stride_c_ff <= csr_data[3:0];
            dis_pkg::REG_PAD_ROWS:      pad_r_ff    <= csr_data[3:0];
            dis_pkg::REG_PAD_COLS:      pad_c_ff    <= csr_data[3:0];
            dis_pkg::REG_DILATION_ROWS: dil_r_ff    <= csr_data[3:0];
            dis_pkg::REG_DILATION_COLS: dil_c_ff    <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic skid_v_ff;
   logic adv;
   assign adv        = !skid_v_ff;
   assign req_tready = adv;

   // stage 1: capture
   logic        s1_v_ff, s1_mode_ff;
   logic [11:0] s1_idx_ff;
   logic [15:0] s1_pix_ff;
   logic [3:0]  s1_kr_ff, s1_kc_ff;
   logic [5:0]  s1_or_ff, s1_oc_ff;
   logic signed [15:0] s1_ofr_ff, s1_ofc_ff;

   // stage 2: Q12.8 position
   logic        s2_v_ff, s2_mode_ff;
   logic [11:0] s2_idx_ff;
   logic [15:0] s2_pix_ff;
   logic signed [19:0] s2_pr_ff, s2_pc_ff;
   logic [9:0]  prod_or, prod_oc;
   logic [7:0]  prod_kr, prod_kc;
   logic signed [11:0] int_r, int_c;
   logic signed [19:0] s2_pr_in, s2_pc_in;

   assign prod_or  = 10'(s1_or_ff) * 10'(stride_r_ff);
   assign prod_oc  = 10'(s1_oc_ff) * 10'(stride_c_ff);
   assign prod_kr  = 8'(s1_kr_ff) * 8'(dil_r_ff);
   assign prod_kc  = 8'(s1_kc_ff) * 8'(dil_c_ff);
   assign int_r    = $signed(12'(prod_or) + 12'(prod_kr)) - $signed(12'(pad_r_ff));
   assign int_c    = $signed(12'(prod_oc) + 12'(prod_kc)) - $signed(12'(pad_c_ff));
   assign s2_pr_in = $signed({int_r, 8'b0}) + 20'(s1_ofr_ff);
   assign s2_pc_in = $signed({int_c, 8'b0}) + 20'(s1_ofc_ff);

   // stage 3: inside test, floor and fraction
   logic        s3_v_ff, s3_mode_ff, s3_in_ff;
   logic [11:0] s3_idx_ff;
   logic [15:0] s3_pix_ff;
   logic signed [11:0] s3_rl_ff, s3_cl_ff;
   logic [7:0]  s3_lr_ff, s3_lc_ff;
   logic signed [19:0] bias_r, bias_c;
   logic        s3_in_in;

   assign bias_r   = s2_pr_ff + 20'sd256;
   assign bias_c   = s2_pc_ff + 20'sd256;
   assign s3_in_in = (s2_pr_ff > -20'sd256) && (s2_pc_ff > -20'sd256)
                  && (s2_pr_ff < $signed({5'b0, height_ff, 8'b0}))
                  && (s2_pc_ff < $signed({5'b0, width_ff, 8'b0}));

   // stage 4: neighbour addresses and corner weights
   logic        s4_v_ff, s4_mode_ff, s4_in_ff;
   logic [11:0] s4_idx_ff;
   logic [15:0] s4_pix_ff;
   logic [AW-1:0] s4_a00_ff, s4_a01_ff, s4_a10_ff, s4_a11_ff;
   logic        s4_ok00_ff, s4_ok01_ff, s4_ok10_ff, s4_ok11_ff;
   logic [16:0] s4_w00_ff, s4_w01_ff, s4_w10_ff, s4_w11_ff;
   logic signed [11:0] h_s, w_s;
   logic        r0ok, r1ok, c0ok, c1ok;
   logic signed [23:0] base, a00, a01, a10, a11;
   logic [8:0]  hr, hc, lr9, lc9;
   logic [17:0] t00, t01, t10, t11;

   assign h_s  = $signed(12'(height_ff));
   assign w_s  = $signed(12'(width_ff));
   assign r0ok = s3_in_ff && (s3_rl_ff >= 12'sd0);
   assign r1ok = s3_in_ff && ((s3_rl_ff + 12'sd1) < h_s);
   assign c0ok = (s3_cl_ff >= 12'sd0);
   assign c1ok = ((s3_cl_ff + 12'sd1) < w_s);
   assign base = s3_rl_ff * w_s;
   assign a00  = base + 24'(s3_cl_ff);
   assign a01  = a00 + 24'sd1;
   assign a10  = a00 + 24'(w_s);
   assign a11  = a10 + 24'sd1;
   assign lr9  = {1'b0, s3_lr_ff};
   assign lc9  = {1'b0, s3_lc_ff};
   assign hr   = 9'd256 - lr9;
   assign hc   = 9'd256 - lc9;
   assign t00  = 18'(hr) * 18'(hc);
   assign t01  = 18'(hr) * 18'(lc9);
   assign t10  = 18'(lr9) * 18'(hc);
   assign t11  = 18'(lr9) * 18'(lc9);

   // stage 5: plane read (loads write here)
   logic        s5_v_ff, s5_in_ff;
   logic        s5_ok00_ff, s5_ok01_ff, s5_ok10_ff, s5_ok11_ff;
   logic [16:0] s5_w00_ff, s5_w01_ff, s5_w10_ff, s5_w11_ff;
   logic [31:0] idx_l;
   logic        wr_en;
   logic [15:0] rd00, rd01, rd10, rd11;

   assign idx_l = 32'(s4_idx_ff);
   assign wr_en = adv && s4_v_ff && (s4_mode_ff == dis_pkg::MODE_LOAD) && (idx_l < DEPTH_L);

   dis_plane_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_top (
      .clock     (clock),
      .rd_en     (adv),
      .wr_en     (wr_en),
      .wr_addr   (idx_l[AW-1:0]),
      .wr_data   (s4_pix_ff),
      .rd_addr_a (s4_a00_ff),
      .rd_addr_b (s4_a01_ff),
      .rd_data_a (rd00),
      .rd_data_b (rd01)
   );

   dis_plane_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_bot (
      .clock     (clock),
      .rd_en     (adv),
      .wr_en     (wr_en),
      .wr_addr   (idx_l[AW-1:0]),
      .wr_data   (s4_pix_ff),
      .rd_addr_a (s4_a10_ff),
      .rd_addr_b (s4_a11_ff),
      .rd_data_a (rd10),
      .rd_data_b (rd11)
   );

   // stage 6: weighted corners
   logic        s6_v_ff, s6_in_ff;
   logic signed [33:0] s6_p00_ff, s6_p01_ff, s6_p10_ff, s6_p11_ff;
   logic signed [15:0] px00, px01, px10, px11;

   assign px00 = s5_ok00_ff ? $signed(rd00) : 16'sd0;
   assign px01 = s5_ok01_ff ? $signed(rd01) : 16'sd0;
   assign px10 = s5_ok10_ff ? $signed(rd10) : 16'sd0;
   assign px11 = s5_ok11_ff ? $signed(rd11) : 16'sd0;

   // final sum, floor by the arithmetic shift
   logic signed [35:0] sum;
   logic [15:0] res_val;
   assign sum     = 36'(s6_p00_ff) + 36'(s6_p01_ff) + 36'(s6_p10_ff) + 36'(s6_p11_ff);
   assign res_val = s6_in_ff ? sum[31:16] : 16'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_tvalid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         // drop loads once they have written the plane
         s5_v_ff <= s4_v_ff && (s4_mode_ff == dis_pkg::MODE_SAMPLE);
         s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mode_ff <= req_tuser;
         s1_idx_ff  <= req_tdata[11:0];
         s1_pix_ff  <= req_tdata[27:12];
         s1_kr_ff   <= req_tdata[31:28];
         s1_kc_ff   <= req_tdata[35:32];
         s1_or_ff   <= req_tdata[41:36];
         s1_oc_ff   <= req_tdata[47:42];
         s1_ofr_ff  <= $signed(req_tdata[63:48]);
         s1_ofc_ff  <= $signed(req_tdata[79:64]);

         s2_mode_ff <= s1_mode_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_pix_ff  <= s1_pix_ff;
         s2_pr_ff   <= s2_pr_in;
         s2_pc_ff   <= s2_pc_in;

         s3_mode_ff <= s2_mode_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_pix_ff  <= s2_pix_ff;
         s3_in_ff   <= s3_in_in;
         s3_rl_ff   <= $signed(bias_r[19:8]) - 12'sd1;
         s3_cl_ff   <= $signed(bias_c[19:8]) - 12'sd1;
         s3_lr_ff   <= bias_r[7:0];
         s3_lc_ff   <= bias_c[7:0];

         s4_mode_ff <= s3_mode_ff;
         s4_idx_ff  <= s3_idx_ff;
         s4_pix_ff  <= s3_pix_ff;
         s4_in_ff   <= s3_in_ff;
         s4_a00_ff  <= a00[AW-1:0];
         s4_a01_ff  <= a01[AW-1:0];
         s4_a10_ff  <= a10[AW-1:0];
         s4_a11_ff  <= a11[AW-1:0];
         s4_ok00_ff <= r0ok && c0ok && (a00 < DEPTH_W);
         s4_ok01_ff <= r0ok && c1ok && (a01 < DEPTH_W);
         s4_ok10_ff <= r1ok && c0ok && (a10 < DEPTH_W);
         s4_ok11_ff <= r1ok && c1ok && (a11 < DEPTH_W);
         s4_w00_ff  <= t00[16:0];
         s4_w01_ff  <= t01[16:0];
         s4_w10_ff  <= t10[16:0];
         s4_w11_ff  <= t11[16:0];

         s5_in_ff   <= s4_in_ff;
         s5_ok00_ff <= s4_ok00_ff;
         s5_ok01_ff <= s4_ok01_ff;
         s5_ok10_ff <= s4_ok10_ff;
         s5_ok11_ff <= s4_ok11_ff;
         s5_w00_ff  <= s4_w00_ff;
         s5_w01_ff  <= s4_w01_ff;
         s5_w10_ff  <= s4_w10_ff;
         s5_w11_ff  <= s4_w11_ff;

         s6_in_ff   <= s5_in_ff;
         s6_p00_ff  <= $signed({1'b0, s5_w00_ff}) * px00;
         s6_p01_ff  <= $signed({1'b0, s5_w01_ff}) * px01;
         s6_p10_ff  <= $signed({1'b0, s5_w10_ff}) * px10;
         s6_p11_ff  <= $signed({1'b0, s5_w11_ff}) * px11;
      end
   end

   // output register with skid entry
   logic        out_v_ff, out_in_ff, skid_in_ff;
   logic [15:0] out_val_ff, skid_val_ff;
   logic        pop, push;

   assign pop  = out_v_ff && rsp_tready;
   assign push = adv && s6_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            out_val_ff <= skid_val_ff;
            out_in_ff  <= skid_in_ff;
            skid_v_ff  <= 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || pop) begin
            out_v_ff   <= 1'b1;
            out_val_ff <= res_val;
            out_in_ff  <= s6_in_ff;
         end else begin
            skid_v_ff   <= 1'b1;
            skid_val_ff <= res_val;
            skid_in_ff  <= s6_in_ff;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_val_ff;
   assign rsp_tuser  = out_in_ff;

endmodule

// ===== sv/dis_checker.sv =====
// Port-level checker for the deformable im2col sampler, bound to the top level.
// Depends on deformable_im2col_sampler_macros.svh.
`include "deformable_im2col_sampler_macros.svh"

module dis_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic [15:0] rsp_tdata,
   input logic        csr_ready
);

   `DIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   `DIS_ASSERT_NOW(a_outside_zero, clock, reset, rsp_tvalid && (rsp_tuser == 1'b0), rsp_tdata == 16'd0, "outside sample with non-zero value")

   `DIS_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_tvalid, req_tready, "input stalled with output empty")

   `DIS_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "configuration port not ready")

endmodule

bind deformable_im2col_sampler dis_checker u_dis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);
